// ----- hdl/czw_pkg.sv -----
// ----------------------------------------------------------------------------
// czw_pkg
// shared types and constants of the zero padded 2d window filter
// ----------------------------------------------------------------------------
`default_nettype none

package czw_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_KERNEL = 5;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 11;

    localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_KERNEL = 2'd2;

    localparam logic [10:0] RST_HEIGHT = 11'd1024;
    localparam logic [10:0] RST_WIDTH  = 11'd1024;
    localparam logic [2:0]  RST_KERNEL = 3'd3;

    typedef enum logic [1:0] {
        REQ_COEF  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

endpackage

`default_nettype wire

// ----- hdl/czw_if.sv -----
// ----------------------------------------------------------------------------
// czw_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface czw_in_if
    import czw_pkg::*;
();
    logic               valid;
    logic               ready;
    t_req               req_type;
    logic        [4:0]  coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] pixel_value;

    modport source (output valid, req_type, coef_index, coef_value, pixel_value,
                    input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, pixel_value,
                    output ready);
endinterface

interface czw_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] conv_sum;
    logic        [9:0]  out_row;
    logic        [9:0]  out_col;
    logic               end_of_frame;

    modport source (output valid, conv_sum, out_row, out_col, end_of_frame,
                    input ready);
    modport sink   (input valid, conv_sum, out_row, out_col, end_of_frame,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/conv2d_zero_pad_window.sv -----
// ----------------------------------------------------------------------------
// conv2d_zero_pad_window
// streaming kxk correlation over a raster frame with zero padded borders
// ----------------------------------------------------------------------------
// Takes one item per clock: coefficient loads, pixels in raster order and
// flush ticks. Each pixel or flush item is written to a ring of MAX_KERNEL+1
// single-port line buffer banks that are all read at the same column, so a
// full column of the window is formed per item and shifted into a window
// register array. An output for position (r,c) leaves with the item whose
// stream index is (r,c) plus (K/2)*width+K/2; after the frame the host sends
// that many flush ticks. The path is five register stages deep (line buffer
// read, window, products, row sums, result) and sustains one item per clock
// whenever the result side takes one result per clock. Configuration writes
// restart the frame and must be made while no item is in flight.
`default_nettype none

module conv2d_zero_pad_window
    import czw_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    czw_in_if.sink                 i_item,
    czw_out_if.source              o_result
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int OW  = $clog2(MAX_HEIGHT);
    localparam int RW  = $clog2(MAX_HEIGHT + MAX_KERNEL + 2);
    localparam int NB  = MAX_KERNEL + 1;
    localparam int BW  = $clog2(NB);
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int NC  = MAX_KERNEL * MAX_KERNEL;
    localparam int CXW = (NC > 1) ? $clog2(NC) : 1;
    localparam int MXD = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int XW  = $clog2(MXD + MAX_KERNEL + 1) + 1;
    localparam int NW  = $clog2(MAX_HEIGHT * MAX_WIDTH + MAX_KERNEL * MAX_WIDTH
                                + MAX_KERNEL + 1);

    // configuration
    logic [10:0] r_cfg_h;
    logic [10:0] r_cfg_w;
    logic [2:0]  r_cfg_k;
    logic        cfg_hit;

    logic [12:0]   h_ext;
    logic [12:0]   w_ext;
    logic [3:0]    k_ext;
    logic [HW-1:0] h_v;
    logic [WW-1:0] w_v;
    logic [KW-1:0] k_v;
    logic [KW-1:0] z_v;

    // stream position
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [NW-1:0] r_in_cnt;
    logic [BW-1:0] r_bank;
    logic [OW-1:0] r_or;
    logic [CW-1:0] r_oc;

    logic en;
    logic acc;
    logic adv;
    logic col_last;
    logic [NW-1:0] lag_v;
    logic start;
    logic eof_hit;
    logic mem_we;
    logic signed [15:0] wdata;

    // stage 1
    logic               r_s1_v;
    logic               r_s1_adv;
    logic               r_s1_out;
    logic               r_s1_coef;
    logic [4:0]         r_s1_idx;
    logic signed [15:0] r_s1_cval;
    logic signed [15:0] r_s1_pix;
    logic [BW-1:0]      r_s1_bank;
    logic [OW-1:0]      r_s1_r;
    logic [CW-1:0]      r_s1_c;
    logic               r_s1_eof;
    logic signed [15:0] r_rd [NB];
    logic signed [15:0] colv [NB];

    // stage 2
    logic               r_s2_v;
    logic               r_s2_out;
    logic               r_s2_coef;
    logic [4:0]         r_s2_idx;
    logic signed [15:0] r_s2_cval;
    logic [OW-1:0]      r_s2_r;
    logic [CW-1:0]      r_s2_c;
    logic               r_s2_eof;
    logic signed [15:0] r_win [NB][NB];
    logic signed [15:0] r_coef [NC];
    logic [NB-1:0]      rowok;
    logic [NB-1:0]      colok;
    logic signed [15:0] csel [NB][NB];
    logic signed [31:0] n_prod [NB][NB];

    // stage 3
    logic               r_s3_v;
    logic [OW-1:0]      r_s3_r;
    logic [CW-1:0]      r_s3_c;
    logic               r_s3_eof;
    logic signed [31:0] r_prod [NB][NB];
    logic signed [39:0] n_rsum [NB];

    // stage 4
    logic               r_s4_v;
    logic [OW-1:0]      r_s4_r;
    logic [CW-1:0]      r_s4_c;
    logic               r_s4_eof;
    logic signed [39:0] r_rsum [NB];
    logic signed [39:0] n_sum;

    // result
    logic               r_out_v;
    logic signed [39:0] r_sum;
    logic [OW-1:0]      r_out_r;
    logic [CW-1:0]      r_out_c;
    logic               r_out_e;

    always_comb begin
        h_ext = 13'(r_cfg_h);
        w_ext = 13'(r_cfg_w);
        k_ext = 4'(r_cfg_k);
        if (h_ext == 13'd0) begin
            h_v = HW'(1);
        end else if (h_ext > 13'(MAX_HEIGHT)) begin
            h_v = HW'(MAX_HEIGHT);
        end else begin
            h_v = HW'(h_ext);
        end
        if (w_ext == 13'd0) begin
            w_v = WW'(1);
        end else if (w_ext > 13'(MAX_WIDTH)) begin
            w_v = WW'(MAX_WIDTH);
        end else begin
            w_v = WW'(w_ext);
        end
        if (k_ext == 4'd0) begin
            k_v = KW'(1);
        end else if (k_ext > 4'(MAX_KERNEL)) begin
            k_v = KW'(MAX_KERNEL);
        end else begin
            k_v = KW'(k_ext);
        end
        z_v = k_v >> 1;
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_HEIGHT || i_cfg_index == CFG_WIDTH
                                  || i_cfg_index == CFG_KERNEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_h <= RST_HEIGHT;
            r_cfg_w <= RST_WIDTH;
            r_cfg_k <= RST_KERNEL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_KERNEL: r_cfg_k <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign en  = !r_out_v || o_result.ready;
    assign acc = i_item.valid && en;
    assign i_item.ready = en;
    assign adv = (i_item.req_type == REQ_PIXEL) || (i_item.req_type == REQ_FLUSH);

    always_comb begin
        col_last = (WW'(r_in_col) + WW'(1)) >= w_v;
        lag_v    = NW'(z_v) * NW'(w_v) + NW'(z_v);
        start    = r_in_cnt >= lag_v;
        eof_hit  = (r_or == OW'(h_v - HW'(1))) && (r_oc == CW'(w_v - WW'(1)));
        mem_we   = acc && adv && (r_in_row < RW'(h_v));
        wdata    = (i_item.req_type == REQ_PIXEL) ? i_item.pixel_value : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_in_cnt <= '0;
            r_bank   <= '0;
            r_or     <= '0;
            r_oc     <= '0;
        end else if (acc && adv) begin
            r_in_cnt <= r_in_cnt + NW'(1);
            if (col_last) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + RW'(1);
                r_bank   <= (r_bank == BW'(NB - 1)) ? '0 : r_bank + BW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
            if (start) begin
                if (r_oc == CW'(w_v - WW'(1))) begin
                    r_oc <= '0;
                    r_or <= r_or + OW'(1);
                end else begin
                    r_oc <= r_oc + CW'(1);
                end
                if (eof_hit) begin
                    r_in_col <= '0;
                    r_in_row <= '0;
                    r_in_cnt <= '0;
                    r_bank   <= '0;
                    r_or     <= '0;
                    r_oc     <= '0;
                end
            end
        end
    end

    // line buffer ring, one bank per row slot
    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic signed [15:0] mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (mem_we && r_bank == BW'(b)) begin
                mem[r_in_col] <= wdata;
            end
            if (en) begin
                r_rd[b] <= mem[r_in_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_adv  <= adv;
            r_s1_out  <= adv && start;
            r_s1_coef <= i_item.req_type == REQ_COEF;
            r_s1_idx  <= i_item.coef_index;
            r_s1_cval <= i_item.coef_value;
            r_s1_pix  <= wdata;
            r_s1_bank <= r_bank;
            r_s1_r    <= r_or;
            r_s1_c    <= r_oc;
            r_s1_eof  <= eof_hit;
        end
    end

    // column of the window: current item and the rows above it
    always_comb begin
        logic [BW:0] bi;
        colv[0] = r_s1_pix;
        for (int t = 1; t < NB; t++) begin
            bi = (BW+1)'(r_s1_bank) + (BW+1)'(NB - t);
            if (bi >= (BW+1)'(NB)) begin
                bi = bi - (BW+1)'(NB);
            end
            colv[t] = r_rd[bi[BW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v && (r_s1_out || r_s1_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_out  <= r_s1_out;
            r_s2_coef <= r_s1_coef;
            r_s2_idx  <= r_s1_idx;
            r_s2_cval <= r_s1_cval;
            r_s2_r    <= r_s1_r;
            r_s2_c    <= r_s1_c;
            r_s2_eof  <= r_s1_eof;
            if (r_s1_v && r_s1_adv) begin
                for (int t = 0; t < NB; t++) begin
                    r_win[t][0] <= colv[t];
                    for (int d = 1; d < NB; d++) begin
                        r_win[t][d] <= r_win[t][d-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_v && r_s2_coef && 32'(r_s2_idx) < NC) begin
            r_coef[CXW'(r_s2_idx)] <= r_s2_cval;
        end
    end

    // border masks in window coordinates
    always_comb begin
        logic [XW-1:0] ar;
        logic [XW-1:0] ac;
        ar = XW'(r_s2_r) + XW'(z_v);
        ac = XW'(r_s2_c) + XW'(z_v);
        for (int t = 0; t < NB; t++) begin
            rowok[t] = (ar >= XW'(t)) && ((ar - XW'(t)) < XW'(h_v));
            colok[t] = (ac >= XW'(t)) && ((ac - XW'(t)) < XW'(w_v));
        end
    end

    for (genvar t = 0; t < NB; t++) begin : g_row
        for (genvar d = 0; d < NB; d++) begin : g_col
            logic signed [15:0] cand [MAX_KERNEL];
            for (genvar kk = 1; kk <= MAX_KERNEL; kk++) begin : g_k
                localparam int KR = 2 * (kk / 2) - t;
                localparam int KC = 2 * (kk / 2) - d;
                if (KR >= 0 && KR < kk && KC >= 0 && KC < kk) begin : g_on
                    assign cand[kk-1] = r_coef[KR * kk + KC];
                end else begin : g_off
                    assign cand[kk-1] = 16'sd0;
                end
            end
            always_comb begin
                csel[t][d] = 16'sd0;
                for (int kk = 0; kk < MAX_KERNEL; kk++) begin
                    if (k_v == KW'(kk + 1)) begin
                        csel[t][d] = cand[kk];
                    end
                end
                n_prod[t][d] = (rowok[t] && colok[d]) ? r_win[t][d] * csel[t][d] : 32'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v && r_s2_out;
            r_s4_v <= r_s3_v;
        end
    end

    always_comb begin
        for (int t = 0; t < NB; t++) begin
            n_rsum[t] = 40'sd0;
            for (int d = 0; d < NB; d++) begin
                n_rsum[t] = n_rsum[t] + 40'(r_prod[t][d]);
            end
        end
        n_sum = 40'sd0;
        for (int t = 0; t < NB; t++) begin
            n_sum = n_sum + r_rsum[t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_r   <= r_s2_r;
            r_s3_c   <= r_s2_c;
            r_s3_eof <= r_s2_eof;
            r_prod   <= n_prod;
            r_s4_r   <= r_s3_r;
            r_s4_c   <= r_s3_c;
            r_s4_eof <= r_s3_eof;
            r_rsum   <= n_rsum;
            r_sum    <= n_sum;
            r_out_r  <= r_s4_r;
            r_out_c  <= r_s4_c;
            r_out_e  <= r_s4_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_s4_v;
        end
    end

    assign o_result.valid        = r_out_v;
    assign o_result.conv_sum     = r_sum;
    assign o_result.out_row      = 10'(r_out_r);
    assign o_result.out_col      = 10'(r_out_c);
    assign o_result.end_of_frame = r_out_e;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < w_v)
        else $error("input column beyond frame width");

    a_out_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (HW'(r_out_r) < h_v))
        else $error("result row beyond frame height");

    a_eof_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_e) |-> (r_out_c == CW'(w_v - WW'(1))))
        else $error("end of frame away from last column");
`endif

endmodule

`default_nettype wire

// ----- bench/conv2d_zero_pad_window_test.sv -----
// ----------------------------------------------------------------------------
// conv2d_zero_pad_window_test
// self-checking bench for the zero padded 2d window filter
// ----------------------------------------------------------------------------
// Loads kernels, streams small frames with flush items and checks every
// windowed sum and its position against a behavioral predictor of the filter.
// Sender gaps and receiver stalls are random, and one long receiver hold-off
// fills the pipeline so the block must stall its input.
`default_nettype none

module conv2d_zero_pad_window_test;
    import czw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int MAXK = 5;
    localparam int RING = 2 * MAXK;

    typedef struct packed {
        logic signed [39:0] conv_sum;
        logic        [9:0]  out_row;
        logic        [9:0]  out_col;
        logic               end_of_frame;
    } t_pixel_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    czw_in_if  item_ch ();
    czw_out_if res_ch ();

    conv2d_zero_pad_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_ch.sink),
        .o_result    (res_ch.source)
    );

    // predictor state
    int         coef_mem [MAXK*MAXK];
    int         line_mem [RING][MAXW];
    int         cfg_h, cfg_w, cfg_k;
    int         row_pos, col_pos, out_pos;
    t_pixel_out sums_due [$];
    int         err_count;
    int         hold_cycles;
    int         gap_max;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void predict_window(t_req kind, int idx, int cval, int pval);
        int h, w, k, z, lag, n, r, c, x, y;
        longint acc;
        t_pixel_out res;
        if (kind == REQ_COEF) begin
            if (idx < MAXK*MAXK) coef_mem[idx] = cval;
            return;
        end
        if (kind == REQ_NONE) return;
        h = clampi(cfg_h, 1, MAXH);
        w = clampi(cfg_w, 1, MAXW);
        k = clampi(cfg_k, 1, MAXK);
        z = k / 2;
        lag = z * w + z;
        n = row_pos * w + col_pos;
        if (row_pos < h && col_pos < w)
            line_mem[row_pos % RING][col_pos] = (kind == REQ_PIXEL) ? pval : 0;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (n < lag) return;
        r = out_pos / w;
        c = out_pos % w;
        acc = 0;
        for (int kr = 0; kr < k; kr++) begin
            x = r + kr - z;
            if (x < 0 || x >= h) continue;
            for (int kc = 0; kc < k; kc++) begin
                y = c + kc - z;
                if (y < 0 || y >= w) continue;
                acc += longint'(line_mem[x % RING][y]) * longint'(coef_mem[kr*k+kc]);
            end
        end
        out_pos++;
        res.end_of_frame = 1'b0;
        if (out_pos >= h * w) begin
            res.end_of_frame = 1'b1;
            row_pos = 0; col_pos = 0; out_pos = 0;
        end
        res.conv_sum = acc[39:0];
        res.out_row = r[9:0];
        res.out_col = c[9:0];
        sums_due.push_back(res);
    endfunction

    task automatic send_item(t_req kind, int idx, int cval, int pval);
        if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.req_type    <= kind;
        item_ch.coef_index  <= idx[4:0];
        item_ch.coef_value  <= cval[15:0];
        item_ch.pixel_value <= pval[15:0];
        do @(posedge i_clk); while (!item_ch.ready);
        predict_window(kind, idx, $signed(cval[15:0]), $signed(pval[15:0]));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        item_ch.valid <= 1'b0;
        while (sums_due.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DW-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEIGHT) cfg_h = val & 11'h7ff;
        else if (idx == CFG_WIDTH) cfg_w = val & 11'h7ff;
        else cfg_k = val & 3'h7;
        row_pos = 0; col_pos = 0; out_pos = 0;
    endtask

    task automatic load_kernel(int k, bit extremes);
        int v;
        for (int i = 0; i < k*k; i++) begin
            v = extremes ? ((i % 2) ? -32768 : 32767) : $urandom_range(0, 65535);
            send_item(REQ_COEF, i, v, 0);
        end
    endtask

    task automatic run_frame(int h, int w, int k, int mode);
        int pv, z;
        z = k / 2;
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_KERNEL, k);
        for (int i = 0; i < h*w; i++) begin
            case (mode)
                0: pv = (i % 2) ? -32768 : 32767;
                default: pv = $urandom_range(0, 65535);
            endcase
            if (mode == 2 && $urandom_range(0, 15) == 0)
                send_item(REQ_COEF, $urandom_range(0, k*k-1), $urandom_range(0, 65535), 0);
            if (mode == 2 && $urandom_range(0, 15) == 0)
                send_item(REQ_NONE, $urandom_range(0, 31), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            send_item(REQ_PIXEL, 0, 0, pv);
        end
        for (int i = 0; i < z*w+z; i++)
            if ($urandom_range(0, 3) == 0 && mode == 2)
                send_item(REQ_PIXEL, 0, 0, $urandom_range(0, 65535));
            else
                send_item(REQ_FLUSH, 0, 0, 0);
    endtask

    task automatic test_directed();
        gap_max = 0;
        load_kernel(MAXK, 1'b1);
        run_frame(2, 3, 3, 0);
        send_item(REQ_COEF, 31, 16'h1234, 0);
        send_item(REQ_COEF, 25, 16'h1234, 0);
        run_frame(1, 1, 1, 0);
        run_frame(2, 2, 2, 0);
        // early flush acts as zero pixel
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_KERNEL, 3);
        send_item(REQ_PIXEL, 0, 0, 32767);
        send_item(REQ_FLUSH, 0, 0, 0);
        send_item(REQ_PIXEL, 0, 0, -32768);
        send_item(REQ_PIXEL, 0, 0, 1);
        repeat (3) send_item(REQ_PIXEL, 0, 0, 16'h5a5a);
    endtask

    task automatic test_clamped_dims();
        gap_max = 2;
        run_frame(1, 3, 0, 1);
        run_frame(1, 2, 7, 1);
        write_reg(CFG_HEIGHT, 0);
        write_reg(CFG_WIDTH, 2047);
        write_reg(CFG_KERNEL, 1);
        send_item(REQ_PIXEL, 0, 0, 16'h7fff);
    endtask

    task automatic test_random_frames();
        int k, h, w;
        gap_max = 4;
        for (int f = 0; f < 9; f++) begin
            k = $urandom_range(1, 5);
            h = $urandom_range(1, 6);
            w = $urandom_range(1, 7);
            load_kernel(MAXK, 1'b0);
            if (f == 3) begin
                h = 6;
                w = 7;
                hold_cycles = 200;
                gap_max = 0;
            end
            run_frame(h, w, k, 2);
            gap_max = 4;
        end
        run_frame(5, 5, 5, 2);
    endtask

    // result side: stall pattern and hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected result sum=%0d row=%0d col=%0d", $realtime,
                         res_ch.conv_sum, res_ch.out_row, res_ch.out_col);
                err_count++;
            end else begin
                exp_r = sums_due.pop_front();
                if (res_ch.conv_sum !== exp_r.conv_sum || res_ch.out_row !== exp_r.out_row
                    || res_ch.out_col !== exp_r.out_col
                    || res_ch.end_of_frame !== exp_r.end_of_frame) begin
                    $display("%0t: expected sum=%0d row=%0d col=%0d eof=%0b, got %0d %0d %0d %0b",
                             $realtime, exp_r.conv_sum, exp_r.out_row, exp_r.out_col,
                             exp_r.end_of_frame, res_ch.conv_sum, res_ch.out_row,
                             res_ch.out_col, res_ch.end_of_frame);
                    err_count++;
                end
            end
        end
    end

    initial begin
        err_count = 0;
        hold_cycles = 0;
        gap_max = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_HEIGHT;
        i_cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.req_type = REQ_NONE;
        item_ch.coef_index = '0;
        item_ch.coef_value = '0;
        item_ch.pixel_value = '0;
        res_ch.ready = 1'b0;
        cfg_h = RST_HEIGHT; cfg_w = RST_WIDTH; cfg_k = RST_KERNEL;
        row_pos = 0; col_pos = 0; out_pos = 0;
        foreach (coef_mem[i]) coef_mem[i] = 0;
        foreach (line_mem[i, j]) line_mem[i][j] = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_clamped_dims();
        test_random_frames();
        wait_drained();
        if (err_count == 0 && sums_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
